// ===== design/ckhr_pkg.sv =====
package ckhr_pkg;

  localparam int CHAN_W      = 8;
  localparam int HUE_W       = 9;
  localparam int SAT_W       = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int SECTOR_W    = 4;
  localparam int FRAC_W      = 6;
  localparam int NUM_W       = 14;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HUE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SAT = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [SAT_W-1:0]  SAT_ONE  = 9'd256;

  localparam int HUE_SECTOR_DEG = 60;
  localparam int FRAC_SCALE     = 15360;

  // Hue sectors; codes five and up all take the magenta-to-red branch.
  localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW  = 4'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN = 4'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN  = 4'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE   = 4'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA = 4'd4;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [SAT_W-1:0]    p_scale;
    logic [NUM_W-1:0]    q_scale;
    logic [NUM_W-1:0]    t_scale;
  } hue_params_t;

  typedef struct packed {
    logic              key;
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_word_t;

endpackage

// ===== design/ckhr_in_if.sv =====
interface ckhr_in_if;
  import ckhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_alpha;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  output in_alpha, input ready);
  modport sink (input valid, input in_blue, input in_green, input in_red,
                input in_alpha, output ready);
endinterface

// ===== design/ckhr_out_if.sv =====
interface ckhr_out_if;
  import ckhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_alpha;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output out_alpha, input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                input out_alpha, output ready);
endinterface

// ===== design/color_key_hue_recolor.sv =====
// Color-keyed recolor of ARGB pixels, one word per clock sustained while the output
// is not held. A magenta word (red 255, green 0, blue 255) is the key: its color
// passes unchanged and its alpha becomes 0. Every other word keeps its alpha and its
// value max(r,g,b), takes the configured hue (degrees) and saturation (Q8, values
// above 256 act as 256), and is converted back to RGB with truncating fixed-point
// arithmetic. A word accepted at the input lands in the front register, then moves
// through the queue, a multiply stage and the output register before it is offered
// on the output. The queue of QUEUE_DEPTH words lets the input keep flowing while
// the output is held.
// Configuration is written through cfg_wen, cfg_index and cfg_data (index 0 is the
// hue, index 1 the saturation); the derived sector and scale factors are registered
// on their way to params and settle ahead of any word accepted after the write.
module color_key_hue_recolor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [ckhr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ckhr_pkg::CFG_DATA_W-1:0]  cfg_data,
  ckhr_in_if.sink                          pix_in,
  ckhr_out_if.source                       pix_out
);
  import ckhr_pkg::*;

  // Hue sector and the three scale factors, recomputed from the registers.
  hue_params_t params;

  // Front register to queue.
  logic        front_valid;
  pixel_word_t front_word;
  logic        front_ready;

  // Queue to back end.
  logic        queue_valid;
  pixel_word_t queue_word;
  logic        queue_ready;

  ckhr_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .wen    (cfg_wen),
    .index  (cfg_index),
    .data   (cfg_data),
    .params (params)
  );

  // The front end finds the key color and the value of each word.
  ckhr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .word_valid (front_valid),
    .word       (front_word),
    .word_ready (front_ready)
  );

  ckhr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_word   (front_word),
    .in_ready  (front_ready),
    .out_valid (queue_valid),
    .out_word  (queue_word),
    .out_ready (queue_ready)
  );

  // The back end scales the value into p, q and t and picks the channel order
  // for the sector; key words bypass the arithmetic.
  ckhr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (queue_valid),
    .word       (queue_word),
    .word_ready (queue_ready),
    .params     (params),
    .pix_out    (pix_out)
  );

endmodule

// ===== design/ckhr_cfg.sv =====
module ckhr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wen,
  input  logic [ckhr_pkg::CFG_INDEX_W-1:0] index,
  input  logic [ckhr_pkg::CFG_DATA_W-1:0]  data,
  output ckhr_pkg::hue_params_t            params
);
  import ckhr_pkg::*;

  localparam int MAX_SECTOR = ((1 << HUE_W) - 1) / HUE_SECTOR_DEG;

  logic [HUE_W-1:0]    hue;
  logic [SAT_W-1:0]    sat;
  logic [SECTOR_W-1:0] sector_next;
  logic [HUE_W-1:0]    base_next;
  logic [SAT_W-1:0]    sat_clamped;
  logic [SECTOR_W-1:0] sector_a;
  logic [FRAC_W-1:0]   frac_a;
  logic [SAT_W-1:0]    sat_a;
  logic [15-1:0]       q_mul;
  logic [15-1:0]       t_mul;
  hue_params_t         params_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue <= '0;
      sat <= SAT_ONE;
    end else if (wen) begin
      unique case (index)
        REG_TARGET_HUE: hue <= data[HUE_W-1:0];
        REG_TARGET_SAT: sat <= data[SAT_W-1:0];
      endcase
    end
  end

  // Sector and remainder by comparing against each multiple of 60.
  always_comb begin
    sector_next = '0;
    base_next   = '0;
    for (int k = 1; k <= MAX_SECTOR; k++) begin
      if (hue >= HUE_W'(k * HUE_SECTOR_DEG)) begin
        sector_next = SECTOR_W'(k);
        base_next   = HUE_W'(k * HUE_SECTOR_DEG);
      end
    end
    sat_clamped = (sat > SAT_ONE) ? SAT_ONE : sat;
  end

  always_ff @(posedge clk) begin
    sector_a <= sector_next;
    frac_a   <= FRAC_W'(hue - base_next);
    sat_a    <= sat_clamped;
  end

  always_comb begin
    q_mul = 15'(sat_a) * 15'(frac_a);
    t_mul = 15'(sat_a) * 15'(FRAC_W'(HUE_SECTOR_DEG) - frac_a);
    params_next.sector  = sector_a;
    params_next.p_scale = SAT_ONE - sat_a;
    params_next.q_scale = NUM_W'(15'(FRAC_SCALE) - q_mul);
    params_next.t_scale = NUM_W'(15'(FRAC_SCALE) - t_mul);
  end

  always_ff @(posedge clk) begin
    params <= params_next;
  end

endmodule

// ===== design/ckhr_front.sv =====
module ckhr_front (
  input  logic                  clk,
  input  logic                  rst,
  ckhr_in_if.sink               pix_in,
  output logic                  word_valid,
  output ckhr_pkg::pixel_word_t word,
  input  logic                  word_ready
);
  import ckhr_pkg::*;

  pixel_word_t word_next;
  logic        accept;

  assign pix_in.ready = !word_valid || word_ready;
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    word_next.key   = (pix_in.in_red == CHAN_MAX) && (pix_in.in_green == '0) &&
                      (pix_in.in_blue == CHAN_MAX);
    word_next.value = pix_in.in_red;
    if (pix_in.in_green > word_next.value) begin
      word_next.value = pix_in.in_green;
    end
    if (pix_in.in_blue > word_next.value) begin
      word_next.value = pix_in.in_blue;
    end
    word_next.red   = pix_in.in_red;
    word_next.green = pix_in.in_green;
    word_next.blue  = pix_in.in_blue;
    word_next.alpha = pix_in.in_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (pix_in.ready) begin
      word_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= word_next;
    end
  end

endmodule

// ===== design/ckhr_queue.sv =====
module ckhr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  ckhr_pkg::pixel_word_t in_word,
  output logic                  in_ready,
  output logic                  out_valid,
  output ckhr_pkg::pixel_word_t out_word,
  input  logic                  out_ready
);
  import ckhr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pixel_word_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
  end

endmodule

// ===== design/ckhr_back.sv =====
module ckhr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  word_valid,
  input  ckhr_pkg::pixel_word_t word,
  output logic                  word_ready,
  input  ckhr_pkg::hue_params_t params,
  ckhr_out_if.source            pix_out
);
  import ckhr_pkg::*;

  localparam int           PROD_W      = 22;
  localparam int           RECIP_SHIFT = 16;
  localparam logic [12:0]  RECIP_15    = 13'd4370;

  // x / 15360 == ((x >> 10) / 15) for x below 2^22; y / 15 for a 12-bit y
  // is exact as (y * 4370) >> 16.
  function automatic logic [CHAN_W-1:0] div_frac_scale(input logic [PROD_W-1:0] prod);
    logic [11:0] y;
    logic [24:0] m;
    y = prod[PROD_W-1:10];
    m = 25'(y) * 25'(RECIP_15);
    return m[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
  endfunction

  logic              advance;
  logic              pop;
  logic              s1_valid;
  logic              s1_key;
  logic [CHAN_W-1:0] s1_red;
  logic [CHAN_W-1:0] s1_green;
  logic [CHAN_W-1:0] s1_blue;
  logic [CHAN_W-1:0] s1_alpha;
  logic [CHAN_W-1:0] s1_value;
  logic [SECTOR_W-1:0] s1_sector;
  logic [15:0]       s1_p_prod;
  logic [PROD_W-1:0] s1_q_prod;
  logic [PROD_W-1:0] s1_t_prod;
  logic [16:0]       p_full;
  logic [CHAN_W-1:0] p_val;
  logic [CHAN_W-1:0] q_val;
  logic [CHAN_W-1:0] t_val;
  logic [CHAN_W-1:0] red_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] blue_next;
  logic [CHAN_W-1:0] alpha_next;
  logic              res_valid;
  logic [CHAN_W-1:0] res_red;
  logic [CHAN_W-1:0] res_green;
  logic [CHAN_W-1:0] res_blue;
  logic [CHAN_W-1:0] res_alpha;

  assign advance    = !res_valid || pix_out.ready;
  assign word_ready = advance;
  assign pop        = word_valid && advance;
  assign p_full     = 17'(word.value) * 17'(params.p_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_key    <= word.key;
      s1_red    <= word.red;
      s1_green  <= word.green;
      s1_blue   <= word.blue;
      s1_alpha  <= word.alpha;
      s1_value  <= word.value;
      s1_sector <= params.sector;
      s1_p_prod <= p_full[15:0];
      s1_q_prod <= PROD_W'(word.value) * PROD_W'(params.q_scale);
      s1_t_prod <= PROD_W'(word.value) * PROD_W'(params.t_scale);
    end
  end

  always_comb begin
    p_val = s1_p_prod[15:8];
    q_val = div_frac_scale(s1_q_prod);
    t_val = div_frac_scale(s1_t_prod);
    case (s1_sector)
      SECTOR_RED_YELLOW: begin
        red_next = s1_value; green_next = t_val;    blue_next = p_val;
      end
      SECTOR_YELLOW_GREEN: begin
        red_next = q_val;    green_next = s1_value; blue_next = p_val;
      end
      SECTOR_GREEN_CYAN: begin
        red_next = p_val;    green_next = s1_value; blue_next = t_val;
      end
      SECTOR_CYAN_BLUE: begin
        red_next = p_val;    green_next = q_val;    blue_next = s1_value;
      end
      SECTOR_BLUE_MAGENTA: begin
        red_next = t_val;    green_next = p_val;    blue_next = s1_value;
      end
      default: begin
        red_next = s1_value; green_next = p_val;    blue_next = q_val;
      end
    endcase
    alpha_next = s1_alpha;
    if (s1_key) begin
      red_next   = s1_red;
      green_next = s1_green;
      blue_next  = s1_blue;
      alpha_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_red   <= red_next;
      res_green <= green_next;
      res_blue  <= blue_next;
      res_alpha <= alpha_next;
    end
  end

  assign pix_out.valid     = res_valid;
  assign pix_out.out_red   = res_red;
  assign pix_out.out_green = res_green;
  assign pix_out.out_blue  = res_blue;
  assign pix_out.out_alpha = res_alpha;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckhr_pkg::*;

  // One ARGB pixel, laid out in the same field order as the ports.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } argb_t;

  // A directed row names the register setting it runs under, the pixel word,
  // and, where the answer is obvious, the result typed in by hand.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    argb_t            pixel;
    logic             typed;
    argb_t            result;
  } stim_row_t;

  localparam int DIRECTED_ROWS  = 22;
  localparam int BATCHES        = 12;
  localparam int BATCH_WORDS    = 120;
  localparam int DRAIN_CYCLES   = 20;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ckhr_in_if  pix_in ();
  ckhr_out_if pix_out ();

  color_key_hue_recolor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in.sink),
    .pix_out   (pix_out.source)
  );

  // Our own copy of the two registers, updated at the edge that writes them.
  logic [HUE_W-1:0] hue_setting;
  logic [SAT_W-1:0] sat_setting;

  // Recolored pixels still owed by the block, oldest first.
  argb_t pending_pixels [$];

  int error_count;
  int words_sent;
  int words_checked;
  int settings_used;
  int send_idle_pct;
  int stall_pct;

  stim_row_t directed_rows [DIRECTED_ROWS];

  // 20 ns period: high for half, low for half.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Computes what the block should produce for one pixel under the given
  // hue and saturation. The key color passes through with its alpha cleared;
  // every other pixel keeps its value and alpha and takes the new hue.
  function automatic argb_t recolor_pixel(argb_t px, logic [HUE_W-1:0] hue,
                                          logic [SAT_W-1:0] sat_raw);
    argb_t               res;
    int unsigned         v;
    int unsigned         sat;
    int unsigned         frac;
    int unsigned         p;
    int unsigned         q;
    int unsigned         t;
    logic [SECTOR_W-1:0] sector;
    if (px.red == CHAN_MAX && px.green == '0 && px.blue == CHAN_MAX) begin
      res = px;
      res.alpha = '0;
      return res;
    end
    v = px.red;
    if (px.green > v) v = px.green;
    if (px.blue > v) v = px.blue;
    // Saturation above one is clamped to one, so no term can go negative.
    sat = (sat_raw > SAT_ONE) ? SAT_ONE : sat_raw;
    sector = SECTOR_W'(hue / HUE_SECTOR_DEG);
    frac = hue % HUE_SECTOR_DEG;
    p = (v * (SAT_ONE - sat)) / SAT_ONE;
    q = (v * (FRAC_SCALE - sat * frac)) / FRAC_SCALE;
    t = (v * (FRAC_SCALE - sat * (HUE_SECTOR_DEG - frac))) / FRAC_SCALE;
    res.alpha = px.alpha;
    // Hues of 360 and above land in sectors six to eight, which share the
    // magenta-to-red branch with sector five.
    case (sector)
      SECTOR_RED_YELLOW: begin
        res.red = v[7:0]; res.green = t[7:0]; res.blue = p[7:0];
      end
      SECTOR_YELLOW_GREEN: begin
        res.red = q[7:0]; res.green = v[7:0]; res.blue = p[7:0];
      end
      SECTOR_GREEN_CYAN: begin
        res.red = p[7:0]; res.green = v[7:0]; res.blue = t[7:0];
      end
      SECTOR_CYAN_BLUE: begin
        res.red = p[7:0]; res.green = q[7:0]; res.blue = v[7:0];
      end
      SECTOR_BLUE_MAGENTA: begin
        res.red = t[7:0]; res.green = p[7:0]; res.blue = v[7:0];
      end
      default: begin
        res.red = v[7:0]; res.green = p[7:0]; res.blue = q[7:0];
      end
    endcase
    return res;
  endfunction

  task automatic compare_channel(input string name, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Presents one word, with random idle cycles in front of it, and holds it
  // until the block takes it. The expectation is queued at the accepting edge.
  // Valid is left high on return so that a back-to-back word never sees it
  // lowered and raised within one time step.
  task automatic send_pixel(input argb_t px, input argb_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.in_blue  <= px.blue;
    pix_in.in_green <= px.green;
    pix_in.in_red   <= px.red;
    pix_in.in_alpha <= px.alpha;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pending_pixels = {pending_pixels, want};
    words_sent++;
  endtask

  // Stops sending and waits until every owed word has come back. It always
  // advances at least one edge, so valid is never raised in the step it drops.
  task automatic drain_pipeline();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == REG_TARGET_HUE) hue_setting = value;
    else sat_setting = value;
  endtask

  // Only called with the pipeline empty, so no word in flight sees a change.
  task automatic apply_setting(input logic [HUE_W-1:0] hue,
                               input logic [SAT_W-1:0] sat);
    write_reg(REG_TARGET_HUE, hue);
    write_reg(REG_TARGET_SAT, sat);
    cfg_wen <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // A quarter of the draws hit the edges of the register, including the
  // values past the legal range; the rest spread over the normal span or
  // over the whole nine bits.
  function automatic logic [HUE_W-1:0] pick_hue();
    logic [HUE_W-1:0] edges [4];
    edges = '{9'd0, 9'd359, 9'd360, 9'd511};
    case ($urandom_range(0, 3))
      0: return edges[$urandom_range(0, 3)];
      1: return HUE_W'($urandom_range(0, 511));
      default: return HUE_W'($urandom_range(0, 359));
    endcase
  endfunction

  function automatic logic [SAT_W-1:0] pick_sat();
    logic [SAT_W-1:0] edges [4];
    edges = '{9'd0, 9'd256, 9'd257, 9'd511};
    case ($urandom_range(0, 3))
      0: return edges[$urandom_range(0, 3)];
      1: return SAT_W'($urandom_range(0, 511));
      default: return SAT_W'($urandom_range(0, 256));
    endcase
  endfunction

  // Mostly arbitrary pixels, with a good share of key pixels, pixels one
  // bit away from the key, and grey pixels whose channels are all equal.
  function automatic argb_t pick_pixel();
    argb_t px;
    int    bit_pos;
    px = argb_t'($urandom());
    bit_pos = $urandom_range(0, 3 * CHAN_W - 1);
    case ($urandom_range(0, 9))
      0: begin
        px.red = CHAN_MAX; px.green = '0; px.blue = CHAN_MAX;
      end
      1: begin
        px.red = CHAN_MAX; px.green = '0; px.blue = CHAN_MAX;
        if (bit_pos < CHAN_W) px.red[bit_pos] = ~px.red[bit_pos];
        else if (bit_pos < 2 * CHAN_W) px.green[bit_pos - CHAN_W] = 1'b1;
        else px.blue[bit_pos - 2 * CHAN_W] = ~px.blue[bit_pos - 2 * CHAN_W];
      end
      2: begin
        px.green = px.red; px.blue = px.red;
      end
      default: ;
    endcase
    return px;
  endfunction

  // The receiver drops ready at random according to the current stall rate.
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every word the block hands over is checked against the oldest one owed.
  always @(posedge clk) begin : check_output
    argb_t got;
    argb_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.out_blue, pix_out.out_green, pix_out.out_red,
              pix_out.out_alpha};
      if (pending_pixels.size() == 0) begin
        $error("output word with no pending expectation: %h", got);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        compare_channel("out_blue", want.blue, got.blue);
        compare_channel("out_green", want.green, got.green);
        compare_channel("out_red", want.red, got.red);
        compare_channel("out_alpha", want.alpha, got.alpha);
        words_checked++;
      end
    end
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int send_mix [4];
    int stall_mix [4];
    argb_t px;
    argb_t want;

    // Fields are blue, green, red, alpha. The first rows run under the reset
    // setting (hue 0, full saturation), where a pixel of value v comes out as
    // pure red of brightness v. Zero saturation turns any pixel grey.
    directed_rows = '{
      '{9'd0,   9'd256, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 8'd0, 8'd255, 8'd255}},
      '{9'd0,   9'd256, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0}},
      '{9'd0,   9'd256, '{8'd255, 8'd0, 8'd255, 8'd171}, 1'b1,
        '{8'd255, 8'd0, 8'd255, 8'd0}},
      '{9'd0,   9'd256, '{8'd255, 8'd1, 8'd255, 8'd18}, 1'b0, '0},
      '{9'd0,   9'd256, '{8'd255, 8'd0, 8'd254, 8'd200}, 1'b0, '0},
      '{9'd0,   9'd256, '{8'd255, 8'd0, 8'd255, 8'd255}, 1'b1,
        '{8'd255, 8'd0, 8'd255, 8'd0}},
      '{9'd60,  9'd256, '{8'd50, 8'd200, 8'd10, 8'd77}, 1'b0, '0},
      '{9'd120, 9'd256, '{8'd50, 8'd200, 8'd10, 8'd77}, 1'b0, '0},
      '{9'd180, 9'd256, '{8'd50, 8'd200, 8'd10, 8'd77}, 1'b0, '0},
      '{9'd240, 9'd256, '{8'd50, 8'd200, 8'd10, 8'd77}, 1'b0, '0},
      '{9'd300, 9'd256, '{8'd50, 8'd200, 8'd10, 8'd77}, 1'b0, '0},
      '{9'd359, 9'd256, '{8'd1, 8'd128, 8'd254, 8'd0}, 1'b0, '0},
      '{9'd30,  9'd128, '{8'd90, 8'd60, 8'd30, 8'd128}, 1'b0, '0},
      '{9'd200, 9'd0,   '{8'd56, 8'd34, 8'd12, 8'd9}, 1'b1,
        '{8'd56, 8'd56, 8'd56, 8'd9}},
      '{9'd200, 9'd257, '{8'd56, 8'd34, 8'd12, 8'd9}, 1'b0, '0},
      '{9'd200, 9'd511, '{8'd255, 8'd0, 8'd0, 8'd1}, 1'b0, '0},
      '{9'd360, 9'd256, '{8'd100, 8'd100, 8'd100, 8'd100}, 1'b0, '0},
      '{9'd420, 9'd200, '{8'd3, 8'd2, 8'd1, 8'd254}, 1'b0, '0},
      '{9'd480, 9'd256, '{8'd0, 8'd255, 8'd0, 8'd33}, 1'b0, '0},
      '{9'd511, 9'd100, '{8'd200, 8'd150, 8'd255, 8'd66}, 1'b0, '0},
      '{9'd480, 9'd0,   '{8'd255, 8'd0, 8'd255, 8'd90}, 1'b1,
        '{8'd255, 8'd0, 8'd255, 8'd0}},
      '{9'd511, 9'd511, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0}
    };

    // Four traffic mixes: free flowing, a lazy sender, a slow receiver, and
    // both sides hesitating now and then.
    send_mix  = '{0, 60, 0, 22};
    stall_mix = '{0, 0, 60, 22};

    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    settings_used = 0;
    send_idle_pct = 0;
    stall_pct     = 0;

    rst              = 1'b1;
    cfg_wen          = 1'b0;
    cfg_index        = REG_TARGET_HUE;
    cfg_data         = '0;
    pix_in.valid     = 1'b0;
    pix_in.in_blue   = '0;
    pix_in.in_green  = '0;
    pix_in.in_red    = '0;
    pix_in.in_alpha  = '0;
    pix_out.ready    = 1'b0;
    hue_setting      = 9'd0;
    sat_setting      = SAT_ONE;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The registers are rewritten only when a row asks for a
    // different setting, and only once the pipeline has emptied.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].hue != hue_setting || directed_rows[i].sat != sat_setting) begin
        drain_pipeline();
        apply_setting(directed_rows[i].hue, directed_rows[i].sat);
      end
      px = directed_rows[i].pixel;
      want = directed_rows[i].typed ? directed_rows[i].result
                                    : recolor_pixel(px, hue_setting, sat_setting);
      send_pixel(px, want);
    end

    // Random part: each batch runs one traffic mix under a fresh setting. Half
    // way through a batch the sender holds off until every owed word is back,
    // so the block also sees a completely empty pipeline mid-stream.
    for (int b = 0; b < BATCHES; b++) begin
      drain_pipeline();
      send_idle_pct = send_mix[b % 4];
      stall_pct     = stall_mix[b % 4];
      apply_setting(pick_hue(), pick_sat());
      for (int n = 0; n < BATCH_WORDS; n++) begin
        if (n == BATCH_WORDS / 2) drain_pipeline();
        px = pick_pixel();
        send_pixel(px, recolor_pixel(px, hue_setting, sat_setting));
      end
    end

    // Let the last words come out, then keep watching the output in case the block
    // produces anything it should not.
    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixel words (%0d directed), checked %0d results,",
             words_sent, DIRECTED_ROWS, words_checked);
    $display("across %0d register settings and four sender/receiver traffic mixes.",
             settings_used);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
